FILE: hw/rtl/emrs_pkg.sv
// Shared types and constants for the extent-map read splitter.
package emrs_pkg;

  localparam int OFFSET_W  = 63;
  localparam int LEN_W     = 31;
  localparam int REQ_W     = 32;
  localparam int BLK_W     = 32;
  localparam int SLOT_W    = 3;
  localparam int SHIFT_W   = 5;
  localparam int BYTES_W   = 48;
  localparam int VOL_W     = 49;
  localparam int EXT_CNT_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W   = 2 * BLK_W;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd9;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE_LOG2 = 2'd0,
    REG_LOGICAL_SIZE    = 2'd1,
    REG_EXTENTS_IN_USE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_LEN  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_NEG   = 2'd1,
    CMD_EMPTY = 2'd2,
    CMD_WALK  = 2'd3
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_WALK = 1'b1
  } back_state_t;

  // Classified word passed from front to back
  typedef struct packed {
    cmd_kind_t           kind;
    logic [SLOT_W-1:0]   slot;
    logic [BLK_W-1:0]    start_block;
    logic [BLK_W-1:0]    block_count;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
  } cmd_t;

  // Settings the back end needs while walking
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
  } walk_cfg_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic full;
    logic head_valid;
  } queue_status_t;

  typedef struct packed {
    logic [VOL_W-1:0] volume_offset;
    logic [LEN_W-1:0] segment_length;
    logic [LEN_W-1:0] buffer_offset;
    status_t          status;
    logic             last;
  } result_t;

endpackage

FILE: hw/rtl/emrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module emrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/emrs_queue.sv
// Short command queue between the classifying front and the walking back end.
module emrs_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  emrs_pkg::cmd_t         push_data,
  input  logic                   pop,
  output emrs_pkg::cmd_t         head,
  output emrs_pkg::queue_status_t stat
);
  import emrs_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign head            = entries[rd_ptr];
  assign stat.full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign stat.head_valid = (count != '0);

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("command queue over depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty command queue");

endmodule

FILE: hw/rtl/emrs_front.sv
// Front end: configuration registers, input acceptance and classification of words.
module emrs_front #(
  parameter int MAX_EXTENTS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [emrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [emrs_pkg::OFFSET_W-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  func,
  input  logic [emrs_pkg::SLOT_W-1:0]           entry_index,
  input  logic [emrs_pkg::BLK_W-1:0]            entry_start_block,
  input  logic [emrs_pkg::BLK_W-1:0]            entry_block_count,
  input  logic [emrs_pkg::OFFSET_W-1:0]         byte_offset,
  input  logic signed [emrs_pkg::REQ_W-1:0]     request_length,
  input  emrs_pkg::queue_status_t               q_stat,
  output logic                                  push,
  output emrs_pkg::cmd_t                        push_data,
  output emrs_pkg::walk_cfg_t                   walk_cfg,
  output logic [$clog2(MAX_EXTENTS + 1)-1:0]    n_ext
);
  import emrs_pkg::*;

  localparam int CW = $clog2(MAX_EXTENTS + 1);

  logic [SHIFT_W-1:0]   block_size_log2;
  logic [OFFSET_W-1:0]  logical_size;
  logic [EXT_CNT_W-1:0] extents_in_use;

  logic [OFFSET_W-1:0]  avail;
  logic [LEN_W-1:0]     clamped;
  logic                 keep;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_log2 <= SHIFT_RESET;
      logical_size    <= '0;
      extents_in_use  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCK_SIZE_LOG2: block_size_log2 <= cfg_data[SHIFT_W-1:0];
        REG_LOGICAL_SIZE:    logical_size    <= cfg_data;
        REG_EXTENTS_IN_USE:  extents_in_use  <= cfg_data[EXT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp block size and extent count into range
  always_comb begin
    if (block_size_log2 < SHIFT_MIN) begin
      walk_cfg.shift = SHIFT_MIN;
    end else if (block_size_log2 > SHIFT_MAX) begin
      walk_cfg.shift = SHIFT_MAX;
    end else begin
      walk_cfg.shift = block_size_log2;
    end
    if (32'(extents_in_use) > 32'(MAX_EXTENTS)) begin
      n_ext = CW'(MAX_EXTENTS);
    end else begin
      n_ext = CW'(extents_in_use);
    end
  end

  // Classify the word and clamp the read length to the file size
  always_comb begin
    avail = logical_size - byte_offset;
    if (byte_offset > logical_size) begin
      clamped = '0;
    end else if (OFFSET_W'(request_length[LEN_W-1:0]) > avail) begin
      clamped = avail[LEN_W-1:0];
    end else begin
      clamped = request_length[LEN_W-1:0];
    end

    push_data.slot        = entry_index;
    push_data.start_block = entry_start_block;
    push_data.block_count = entry_block_count;
    push_data.offset      = byte_offset;
    push_data.length      = clamped;
    keep                  = 1'b1;

    if (!func) begin
      push_data.kind = CMD_LOAD;
      keep           = (32'(entry_index) < 32'(MAX_EXTENTS));
    end else if (request_length[REQ_W-1]) begin
      push_data.kind = CMD_NEG;
    end else if (clamped == '0) begin
      push_data.kind = CMD_EMPTY;
    end else begin
      push_data.kind = CMD_WALK;
    end
  end

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready && keep;

endmodule

FILE: hw/rtl/emrs_back.sv
// Back end: extent table, walk over extents and result word register.
module emrs_back #(
  parameter int MAX_EXTENTS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  emrs_pkg::cmd_t                     head,
  input  emrs_pkg::queue_status_t            q_stat,
  output logic                               pop,
  input  emrs_pkg::walk_cfg_t                walk_cfg,
  input  logic [$clog2(MAX_EXTENTS + 1)-1:0] n_ext,
  output logic                               out_valid,
  input  logic                               out_ready,
  output emrs_pkg::result_t                  result
);
  import emrs_pkg::*;

  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  back_state_t         state, state_next;
  logic [CW-1:0]       idx, idx_next, idx_inc;
  logic [OFFSET_W-1:0] in_ext, in_ext_next;
  logic [LEN_W-1:0]    done, done_next;
  logic [LEN_W-1:0]    left, left_next;
  logic                out_valid_next;
  logic                out_load;
  result_t             result_next;

  logic                ram_we;
  logic [AW-1:0]       raddr;
  logic [ENTRY_W-1:0]  rdata;

  logic [BLK_W-1:0]    ent_start, ent_cnt;
  logic [BYTES_W-1:0]  bytes, vstart, diff;
  logic [VOL_W-1:0]    vol;
  logic [LEN_W-1:0]    seg_len;
  logic                hit, fin, exhausted, out_free, adv;

  emrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EXTENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(head.slot)),
    .wdata ({head.start_block, head.block_count}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Evaluate the current extent against the remaining offset and length
  always_comb begin
    ent_start = rdata[ENTRY_W-1:BLK_W];
    ent_cnt   = rdata[BLK_W-1:0];
    bytes     = BYTES_W'(ent_cnt) << walk_cfg.shift;
    vstart    = BYTES_W'(ent_start) << walk_cfg.shift;
    hit       = OFFSET_W'(bytes) > in_ext;
    diff      = bytes - in_ext[BYTES_W-1:0];
    fin       = diff >= BYTES_W'(left);
    seg_len   = fin ? left : diff[LEN_W-1:0];
    vol       = VOL_W'(vstart) + VOL_W'(in_ext[BYTES_W-1:0]);
    exhausted = idx >= n_ext;
    out_free  = !out_valid || out_ready;
    adv       = !exhausted && (!hit || out_free);
    idx_inc   = idx + 1'b1;
  end

  // Next state, queue pop, table write and result word
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    in_ext_next    = in_ext;
    done_next      = done;
    left_next      = left;
    pop            = 1'b0;
    ram_we         = 1'b0;
    out_load       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    result_next    = '{volume_offset: '0, segment_length: '0, buffer_offset: '0,
                       status: ST_OK, last: 1'b1};
    raddr          = '0;

    case (state)
      BK_IDLE: begin
        if (q_stat.head_valid) begin
          case (head.kind)
            CMD_LOAD: begin
              ram_we = 1'b1;
              pop    = 1'b1;
            end
            CMD_NEG: begin
              if (out_free) begin
                pop                = 1'b1;
                out_load           = 1'b1;
                result_next.status = ST_NEG_LEN;
              end
            end
            CMD_EMPTY: begin
              if (out_free) begin
                pop      = 1'b1;
                out_load = 1'b1;
              end
            end
            CMD_WALK: begin
              pop         = 1'b1;
              in_ext_next = head.offset;
              done_next   = '0;
              left_next   = head.length;
              idx_next    = '0;
              state_next  = BK_WALK;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      BK_WALK: begin
        raddr = adv ? idx_inc[AW-1:0] : idx[AW-1:0];
        if (exhausted) begin
          // Out of extents: report overflow with bytes produced so far
          if (out_free) begin
            out_load                  = 1'b1;
            result_next.buffer_offset = done;
            result_next.status        = ST_OVERFLOW;
            state_next                = BK_IDLE;
          end
        end else if (hit) begin
          // Emit one segment from this extent
          if (out_free) begin
            out_load                   = 1'b1;
            result_next.volume_offset  = vol;
            result_next.segment_length = seg_len;
            result_next.buffer_offset  = done;
            result_next.last           = fin;
            done_next                  = done + seg_len;
            left_next                  = left - seg_len;
            in_ext_next                = '0;
            idx_next                   = idx_inc;
            if (fin) begin
              state_next = BK_IDLE;
            end
          end
        end else begin
          // Skip an extent that ends before the start offset
          in_ext_next = in_ext - OFFSET_W'(bytes);
          idx_next    = idx_inc;
        end
      end
      default: state_next = BK_IDLE;
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Hold walk registers and the result word
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    in_ext <= in_ext_next;
    done   <= done_next;
    left   <= left_next;
    if (out_load) begin
      result <= result_next;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_WALK |-> idx <= n_ext)
    else $error("walk index beyond extent count");
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == BK_WALK |-> left != '0)
    else $error("walk continues with nothing left to read");
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status != ST_OK |-> result.last && result.segment_length == '0)
    else $error("error result not final or carries data");

endmodule

FILE: hw/rtl/extent_map_read_splitter.sv
// With the back end idle and the output free, a read's first result word passes the command
// queue and the result register if rejected or empty, else also the extent table read and each
// extent skipped. A load needs no free output; a read holds the back end while it visits table
// entries and reports overflow if they run out; a two-word command queue lets input run ahead.
// Reset (synchronous, rst high) empties the queue and output and restores configuration
// defaults; the extent table is not cleared and must be loaded before use.
module extent_map_read_splitter #(
  parameter int MAX_EXTENTS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [emrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [emrs_pkg::OFFSET_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [emrs_pkg::SLOT_W-1:0]       entry_index,
  input  logic [emrs_pkg::BLK_W-1:0]        entry_start_block,
  input  logic [emrs_pkg::BLK_W-1:0]        entry_block_count,
  input  logic [emrs_pkg::OFFSET_W-1:0]     byte_offset,
  input  logic signed [emrs_pkg::REQ_W-1:0] request_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [emrs_pkg::VOL_W-1:0]        volume_offset,
  output logic [emrs_pkg::LEN_W-1:0]        segment_length,
  output logic [emrs_pkg::LEN_W-1:0]        buffer_offset,
  output logic [1:0]                        status,
  output logic                              last
);
  import emrs_pkg::*;

  localparam int CW = $clog2(MAX_EXTENTS + 1);

  queue_status_t q_stat;
  cmd_t          push_data, head;
  logic          push, pop;
  walk_cfg_t     walk_cfg;
  logic [CW-1:0] n_ext;
  result_t       result;

  emrs_front #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (func),
    .entry_index       (entry_index),
    .entry_start_block (entry_start_block),
    .entry_block_count (entry_block_count),
    .byte_offset       (byte_offset),
    .request_length    (request_length),
    .q_stat            (q_stat),
    .push              (push),
    .push_data         (push_data),
    .walk_cfg          (walk_cfg),
    .n_ext             (n_ext)
  );

  emrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  emrs_back #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .walk_cfg  (walk_cfg),
    .n_ext     (n_ext),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  // Unpack the result word onto the output fields
  assign volume_offset  = result.volume_offset;
  assign segment_length = result.segment_length;
  assign buffer_offset  = result.buffer_offset;
  assign status         = result.status;
  assign last           = result.last;

endmodule

FILE: verif/extent_map_read_splitter_tb.sv
// Self-checking testbench for the extent-map read splitter: directed plan, random phases.
module extent_map_read_splitter_tb;
  import emrs_pkg::*;

  localparam int EXTENTS       = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 43;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [1:0] {
    ROW_CFG  = 2'd0,
    ROW_LOAD = 2'd1,
    ROW_READ = 2'd2
  } row_kind_t;

  // One line of the directed plan
  typedef struct packed {
    row_kind_t           kind;
    cfg_reg_t            sel;
    logic [OFFSET_W-1:0] value;
    logic [SLOT_W-1:0]   slot;
    logic [BLK_W-1:0]    start_block;
    logic [BLK_W-1:0]    block_count;
    logic [REQ_W-1:0]    req_len;
    logic                typed;
    status_t             typed_st;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [OFFSET_W-1:0]   cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  func;
  logic [SLOT_W-1:0]     entry_index;
  logic [BLK_W-1:0]      entry_start_block;
  logic [BLK_W-1:0]      entry_block_count;
  logic [OFFSET_W-1:0]   byte_offset;
  logic signed [REQ_W-1:0] request_length;
  logic                  out_valid;
  logic                  out_ready;
  logic [VOL_W-1:0]      volume_offset;
  logic [LEN_W-1:0]      segment_length;
  logic [LEN_W-1:0]      buffer_offset;
  logic [1:0]            status;
  logic                  last;

  // Mirror of the block's registers and extent table
  logic [SHIFT_W-1:0]    cur_shift   = SHIFT_RESET;
  logic [OFFSET_W-1:0]   cur_size    = '0;
  logic [EXT_CNT_W-1:0]  cur_extents = '0;
  logic [BLK_W-1:0]      tbl_start  [EXTENTS];
  logic [BLK_W-1:0]      tbl_blocks [EXTENTS];

  result_t   pending_segments[$];
  step_row_t plan[$];

  int mismatch_count   = 0;
  int segments_checked = 0;
  int words_sent       = 0;
  int reads_sent       = 0;
  int loads_sent       = 0;
  int settings_used    = 0;
  int quiet_cycles     = 0;
  logic long_hold_go   = 1'b0;
  logic long_hold_done = 1'b0;

  extent_map_read_splitter #(.MAX_EXTENTS(EXTENTS)) uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (func),
    .entry_index       (entry_index),
    .entry_start_block (entry_start_block),
    .entry_block_count (entry_block_count),
    .byte_offset       (byte_offset),
    .request_length    (request_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .volume_offset     (volume_offset),
    .segment_length    (segment_length),
    .buffer_offset     (buffer_offset),
    .status            (status),
    .last              (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- helpers

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [OFFSET_W-1:0] rand_offset();
    logic [63:0] r;
    r = rand64();
    return r[OFFSET_W-1:0];
  endfunction

  // Uniform value in [0, hi]
  function automatic logic [63:0] pick_upto(logic [63:0] hi);
    if (hi == '1) return rand64();
    return rand64() % (hi + 64'd1);
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BLK_W-1:0] pick_blocks();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return $urandom_range(1, 16);
    if (roll < 9) return $urandom_range(17, 4096);
    return $urandom;
  endfunction

  function automatic int eff_shift();
    if (cur_shift < SHIFT_MIN) return SHIFT_MIN;
    if (cur_shift > SHIFT_MAX) return SHIFT_MAX;
    return cur_shift;
  endfunction

  function automatic int eff_extents();
    if (cur_extents > EXTENTS) return EXTENTS;
    return cur_extents;
  endfunction

  // Bytes mapped by the first k extents
  function automatic logic [63:0] prefix_bytes(int k);
    logic [63:0] sum;
    sum = '0;
    for (int i = 0; i < k; i++) sum += {32'd0, tbl_blocks[i]} << eff_shift();
    return sum;
  endfunction

  function automatic void queue_segment(logic [63:0] vol, logic [63:0] seg,
                                        logic [63:0] boff, status_t st, logic lst);
    result_t r;
    r.volume_offset  = vol[VOL_W-1:0];
    r.segment_length = seg[LEN_W-1:0];
    r.buffer_offset  = boff[LEN_W-1:0];
    r.status         = st;
    r.last           = lst;
    pending_segments.insert(pending_segments.size(), r);
  endfunction

  // Split one read into the segment words the block should emit
  function automatic void split_read(logic [OFFSET_W-1:0] off, logic [REQ_W-1:0] req);
    logic [63:0] want, size, start, target, sum_blk, in_ext, done, bytes, seg, vol;
    int shift, n, i;
    if (req[REQ_W-1]) begin
      queue_segment(0, 0, 0, ST_NEG_LEN, 1'b1);
      return;
    end
    size  = {1'b0, cur_size};
    start = {1'b0, off};
    want  = {33'd0, req[REQ_W-2:0]};
    // clamp to the file size
    if (start > size) want = 0;
    else if (want > size - start) want = size - start;
    if (want == 0) begin
      queue_segment(0, 0, 0, ST_OK, 1'b1);
      return;
    end
    shift = eff_shift();
    n = eff_extents();
    // find the extent holding the first block
    target = start >> shift;
    sum_blk = 0;
    for (i = 0; i < n; i++) begin
      if ({32'd0, tbl_blocks[i]} + sum_blk > target) break;
      sum_blk += {32'd0, tbl_blocks[i]};
    end
    if (i >= n) begin
      queue_segment(0, 0, 0, ST_OVERFLOW, 1'b1);
      return;
    end
    // emit one segment per extent touched
    in_ext = start - (sum_blk << shift);
    done = 0;
    while (done < want) begin
      if (i >= n) begin
        queue_segment(0, 0, done, ST_OVERFLOW, 1'b1);
        return;
      end
      bytes = {32'd0, tbl_blocks[i]} << shift;
      if (bytes > in_ext) begin
        seg = bytes - in_ext;
        if (seg > want - done) seg = want - done;
        vol = ({32'd0, tbl_start[i]} << shift) + in_ext;
        queue_segment(vol, seg, done, ST_OK, done + seg >= want);
        done += seg;
      end
      in_ext = 0;
      i++;
    end
  endfunction

  function automatic void add_cfg(cfg_reg_t sel, logic [OFFSET_W-1:0] value);
    step_row_t row;
    row = '0;
    row.kind  = ROW_CFG;
    row.sel   = sel;
    row.value = value;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_load(logic [SLOT_W-1:0] slot, logic [BLK_W-1:0] sb,
                                   logic [BLK_W-1:0] cb);
    step_row_t row;
    row = '0;
    row.kind        = ROW_LOAD;
    row.slot        = slot;
    row.start_block = sb;
    row.block_count = cb;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_read(logic [OFFSET_W-1:0] off, logic [REQ_W-1:0] len,
                                   logic typed, status_t st);
    step_row_t row;
    row = '0;
    row.kind     = ROW_READ;
    row.value    = off;
    row.req_len  = len;
    row.typed    = typed;
    row.typed_st = st;
    plan.insert(plan.size(), row);
  endfunction

  // ------------------------------------------------------------ sender side

  // Offer one word and hold it until accepted, then update the mirror
  task automatic offer_word(input logic f, input logic [SLOT_W-1:0] slot,
                            input logic [BLK_W-1:0] sb, input logic [BLK_W-1:0] cb,
                            input logic [OFFSET_W-1:0] off, input logic [REQ_W-1:0] len,
                            input logic typed, input status_t typed_st);
    in_valid          <= 1'b1;
    func              <= f;
    entry_index       <= slot;
    entry_start_block <= sb;
    entry_block_count <= cb;
    byte_offset       <= off;
    request_length    <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (f == FUNC_LOAD) begin
      tbl_start[slot]  = sb;
      tbl_blocks[slot] = cb;
      loads_sent++;
    end else begin
      reads_sent++;
      if (typed) queue_segment(0, 0, 0, typed_st, 1'b1);
      else split_read(off, len);
    end
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_segments.size() != 0) @(posedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(input cfg_reg_t sel, input logic [OFFSET_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_BLOCK_SIZE_LOG2: cur_shift   = value[SHIFT_W-1:0];
      REG_LOGICAL_SIZE:    cur_size    = value;
      REG_EXTENTS_IN_USE:  cur_extents = value[EXT_CNT_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------- result check

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, want, got);
    end
  endtask

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_segments.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word: vol 0x%0h len %0d buf %0d status %0d last %0d",
                 $time, volume_offset, segment_length, buffer_offset, status, last);
      end else begin
        want = pending_segments.pop_front();
        segments_checked++;
        check_field("volume_offset", want.volume_offset, volume_offset);
        check_field("segment_length", want.segment_length, segment_length);
        check_field("buffer_offset", want.buffer_offset, buffer_offset);
        check_field("status", want.status, status);
        check_field("last", want.last, last);
      end
    end
  end

  // Count cycles in which no word moves on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles, %0d result words still expected",
             $time, QUIET_LIMIT, pending_segments.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stalls, long ready stretches, one long hold-off
  initial begin : receiver
    int n;
    out_ready <= 1'b0;
    wait (!rst);
    forever begin
      if (long_hold_go && !long_hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end
      out_ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      repeat (n) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    step_row_t   row;
    int          roll;
    logic [63:0] off64, rem, cap, len64, size64;
    logic [REQ_W-1:0] len32;

    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    func              <= FUNC_LOAD;
    entry_index       <= '0;
    entry_start_block <= '0;
    entry_block_count <= '0;
    byte_offset       <= '0;
    request_length    <= '0;

    // Reset settings: zero file size, no extents
    add_read(63'd0, 32'd100, 1'b1, ST_OK);
    add_read(63'd0, 32'hFFFF_FFFF, 1'b1, ST_NEG_LEN);
    add_read(63'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b1, ST_NEG_LEN);
    // Fill every slot; slot 2 is a zero-length extent
    add_load(3'd0, 32'h0000_0000, 32'd1);
    add_load(3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_load(3'd2, 32'h1234_5678, 32'd0);
    add_load(3'd3, 32'h0000_1000, 32'd2);
    add_load(3'd4, 32'h7FFF_FFFF, 32'd1);
    add_load(3'd5, 32'h8000_0000, 32'd3);
    add_load(3'd6, 32'h00AB_CDEF, 32'd1);
    add_load(3'd7, 32'h5555_5555, 32'd2);
    // Smallest blocks, largest file, full table
    add_cfg(REG_BLOCK_SIZE_LOG2, 63'd9);
    add_cfg(REG_LOGICAL_SIZE, 63'h7FFF_FFFF_FFFF_FFFF);
    add_cfg(REG_EXTENTS_IN_USE, 63'd8);
    add_read(63'd0, 32'h7FFF_FFFF, 1'b0, ST_OK);
    add_read(63'd0, 32'd0, 1'b1, ST_OK);
    add_read(63'h1FF_FFFF_FFF6, 32'd100, 1'b0, ST_OK);
    add_read(63'h200_0000_0064, 32'd20000, 1'b0, ST_OK);
    add_read(63'h7FFF_FFFF_FFFF_FFF0, 32'd1, 1'b1, ST_OVERFLOW);
    // Out-of-range extent count and block size fall back to the limits
    add_cfg(REG_EXTENTS_IN_USE, 63'd12);
    add_cfg(REG_BLOCK_SIZE_LOG2, 63'd5);
    add_read(63'h200_0000_0064, 32'd20000, 1'b0, ST_OK);
    add_cfg(REG_BLOCK_SIZE_LOG2, 63'd20);
    add_cfg(REG_LOGICAL_SIZE, 63'd1000);
    add_read(63'd1001, 32'd5, 1'b1, ST_OK);
    add_read(63'd900, 32'd500, 1'b0, ST_OK);
    add_read(63'd1000, 32'd1, 1'b1, ST_OK);
    // Largest blocks, no extents in use
    add_cfg(REG_BLOCK_SIZE_LOG2, 63'd16);
    add_cfg(REG_LOGICAL_SIZE, 63'h7FFF_FFFF_FFFF_FFFF);
    add_cfg(REG_EXTENTS_IN_USE, 63'd0);
    add_read(63'd5, 32'd10, 1'b1, ST_OVERFLOW);
    add_cfg(REG_EXTENTS_IN_USE, 63'd3);
    add_read(63'd65535, 32'd70000, 1'b0, ST_OK);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed plan
    foreach (plan[k]) begin
      row = plan[k];
      case (row.kind)
        ROW_CFG: write_reg(row.sel, row.value);
        ROW_LOAD: begin
          offer_word(FUNC_LOAD, row.slot, row.start_block, row.block_count,
                     rand_offset(), $urandom, 1'b0, ST_OK);
          sender_gap(idle_len());
        end
        default: begin
          offer_word(FUNC_READ, SLOT_W'($urandom_range(0, 7)), $urandom, $urandom,
                     row.value, row.req_len, row.typed, row.typed_st);
          sender_gap(idle_len());
        end
      endcase
    end
    settings_used = 5;

    // Random phases, each under fresh register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      write_reg(REG_BLOCK_SIZE_LOG2, ($urandom_range(0, 9) == 0) ?
                $urandom_range(0, 31) : $urandom_range(9, 16));
      roll = $urandom_range(0, 9);
      write_reg(REG_EXTENTS_IN_USE, (roll == 0) ? 0 :
                (roll == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8));
      size64 = prefix_bytes(eff_extents());
      roll = $urandom_range(0, 99);
      if (roll < 50) ;
      else if (roll < 75) size64 = size64 + $urandom_range(1, 1 << 20);
      else if (roll < 88) size64 = pick_upto(size64);
      else if (roll < 94) size64 = 0;
      else size64 = {1'b0, rand_offset()};
      write_reg(REG_LOGICAL_SIZE, size64[OFFSET_W-1:0]);
      settings_used++;

      for (int item = 0; item < PHASE_WORDS; item++) begin
        if (phase == 2 && item == 5) long_hold_go = 1'b1;
        if (phase == 5 && item == 20) wait_drained();
        if ($urandom_range(0, 99) < 20) begin
          offer_word(FUNC_LOAD, SLOT_W'($urandom_range(0, 7)), $urandom, pick_blocks(),
                     rand_offset(), $urandom, 1'b0, ST_OK);
        end else begin
          // start offset: inside the file, at an extent edge, past the end, anywhere
          roll = $urandom_range(0, 99);
          if (roll < 65) off64 = pick_upto({1'b0, cur_size});
          else if (roll < 80) begin
            off64 = prefix_bytes($urandom_range(0, eff_extents()));
            if (off64 >= 2) off64 = off64 - $urandom_range(0, 2);
          end else if (roll < 90) off64 = {1'b0, cur_size} + 64'd1 + $urandom_range(0, 1000);
          else off64 = {1'b0, rand_offset()};
          // length: negative, zero, any, past the end, or a few extents
          roll = $urandom_range(0, 99);
          if (roll < 8) len32 = $urandom | 32'h8000_0000;
          else if (roll < 13) len32 = '0;
          else if (roll < 20) len32 = $urandom & 32'h7FFF_FFFF;
          else begin
            rem = (off64 <= {1'b0, cur_size}) ? {1'b0, cur_size} - off64 : 64'd0;
            if (roll < 32) len64 = rem + $urandom_range(0, 64);
            else begin
              cap = 64'd1 << (eff_shift() + $urandom_range(0, 5));
              if (cap > rem) cap = rem;
              len64 = (cap == 0) ? $urandom_range(1, 4096) : 64'd1 + pick_upto(cap - 64'd1);
            end
            if (len64 > 64'h7FFF_FFFF) len64 = 64'h7FFF_FFFF;
            len32 = len64[REQ_W-1:0];
          end
          offer_word(FUNC_READ, SLOT_W'($urandom_range(0, 7)), $urandom, $urandom,
                     off64[OFFSET_W-1:0], len32, 1'b0, ST_OK);
        end
        // every third phase runs with no sender gaps
        if (phase % 3 != 1) sender_gap(idle_len());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d reads, %0d extent loads) under %0d register settings.",
             words_sent, reads_sent, loads_sent, settings_used);
    $display("Checked %0d result words, %0d mismatches.", segments_checked, mismatch_count);
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
